@@ src/ltw_pkg.sv @@
package ltw_pkg;

  // Default geometry of the text grid and of one character cell.
  localparam int TEXT_COLUMNS_DEF = 12;
  localparam int TEXT_ROWS_DEF    = 6;
  localparam int CELL_PIXELS_DEF  = 7;

  // Serial framing and display controller opcodes.
  localparam int         BYTE_BITS  = 8;
  localparam int         CHAR_BYTES = 7;
  localparam int         GLYPHS     = 96;
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7F;
  localparam logic [7:0] ROW_BASE   = 8'h40;
  localparam logic [7:0] COL_BASE   = 8'h80;

  // Request opcodes.
  typedef enum logic [1:0] {
    CMD_SET_POS  = 2'd0,
    CMD_CHAR     = 2'd1,
    CMD_RAW_CMD  = 2'd2,
    CMD_RAW_DATA = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] value;
    logic [7:0] column;
    logic [7:0] row;
  } request_t;

  typedef struct packed {
    logic serial_bit;
    logic dc_level;
    logic byte_end;
    logic last;
  } result_t;

  // Byte load from the sequencer to the shifter.
  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       dc;
    logic       last_byte;
  } load_t;

  // Shifter status seen by the sequencer.
  typedef struct packed {
    logic active;
    logic ending;
  } shift_status_t;

  // 5x7 font, one 40-bit word per glyph, leftmost column in the top byte.
  localparam logic [39:0] FONT_ROM [GLYPHS] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
    40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
  };

  // One font column of a glyph; columns past the fifth read as blank.
  function automatic logic [7:0] font_column(logic [6:0] glyph, logic [2:0] col);
    logic [39:0] bits;
    logic [7:0]  res;
    bits = FONT_ROM[glyph];
    case (col)
      3'd0:    res = bits[39:32];
      3'd1:    res = bits[31:24];
      3'd2:    res = bits[23:16];
      3'd3:    res = bits[15:8];
      3'd4:    res = bits[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

@@ src/ltw_mod_reduce.sv @@
// Restoring remainder unit: one dividend bit per cycle, MSB first.
module ltw_mod_reduce #(
  parameter int DIVISOR = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic [ltw_pkg::BYTE_BITS-1:0]      dividend,
  output logic                               done,
  output logic [$clog2(DIVISOR+1)-1:0]       remainder
);

  localparam int RW = $clog2(DIVISOR + 1);
  localparam int CW = $clog2(ltw_pkg::BYTE_BITS);

  logic [ltw_pkg::BYTE_BITS-1:0] dv;
  logic [CW-1:0]                 count;
  logic                          running;
  logic [RW:0]                   trial;
  logic [RW-1:0]                 remainder_next;

  // Bring down the next bit and subtract the divisor when it fits.
  always_comb begin
    trial = {remainder, dv[ltw_pkg::BYTE_BITS-1]};
    if (trial >= (RW+1)'(DIVISOR)) begin
      remainder_next = RW'(trial - (RW+1)'(DIVISOR));
    end else begin
      remainder_next = RW'(trial);
    end
  end

  assign done = running && (count == CW'(ltw_pkg::BYTE_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
    end else if (go) begin
      running   <= 1'b1;
      count     <= '0;
      dv        <= dividend;
      remainder <= '0;
    end else if (running) begin
      dv        <= dv << 1;
      remainder <= remainder_next;
      count     <= count + 1'b1;
      if (done) begin
        running <= 1'b0;
      end
    end
  end

endmodule

@@ src/ltw_shifter.sv @@
// Byte shifter: sends a loaded byte MSB first, one bit per cycle.
module ltw_shifter (
  input  logic                     clk,
  input  logic                     rst,
  input  ltw_pkg::load_t           ld,
  output ltw_pkg::shift_status_t   status,
  output logic                     strobe,
  output ltw_pkg::result_t         result
);

  localparam int CW = $clog2(ltw_pkg::BYTE_BITS);

  logic [ltw_pkg::BYTE_BITS-1:0] sreg;
  logic [CW-1:0]                 count;
  logic                          active;
  logic                          dc;
  logic                          last_byte;

  assign status.active = active;
  assign status.ending = active && (count == CW'(ltw_pkg::BYTE_BITS - 1));

  // Output bits come straight from the shift register.
  assign strobe            = active;
  assign result.serial_bit = sreg[ltw_pkg::BYTE_BITS-1];
  assign result.dc_level   = dc;
  assign result.byte_end   = status.ending;
  assign result.last       = status.ending && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
    end else if (ld.load) begin
      active    <= 1'b1;
      count     <= '0;
      sreg      <= ld.data;
      dc        <= ld.dc;
      last_byte <= ld.last_byte;
    end else if (active) begin
      sreg  <= sreg << 1;
      count <= count + 1'b1;
      if (status.ending) begin
        active <= 1'b0;
      end
    end
  end

endmodule

@@ src/lcd_text_serial_writer.sv @@
// Channel   | Ports                  | Transfer
// ----------+------------------------+-----------------------------------------
// request   | start, busy, request   | taken when start is high and busy is low
// result    | strobe, result         | one serial bit per cycle while strobe
//
// The byte shifter sends one bit per clock.
// Set position first passes through the serial remainder units.
// A character code outside the font is taken and gives no result.
// rst is synchronous and returns the sequencer and shifter to idle.
// The receiver cannot stall; bits of one request leave on consecutive cycles.
module lcd_text_serial_writer #(
  parameter int TEXT_COLUMNS = ltw_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = ltw_pkg::TEXT_ROWS_DEF,
  parameter int CELL_PIXELS  = ltw_pkg::CELL_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ltw_pkg::request_t request,
  output logic              strobe,
  output ltw_pkg::result_t  result
);

  localparam int COL_W = $clog2(TEXT_COLUMNS + 1);
  localparam int ROW_W = $clog2(TEXT_ROWS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SEND
  } state_t;

  state_t                 state;
  ltw_pkg::cmd_t          cmd;
  logic [7:0]             value;
  logic [2:0]             byte_idx;
  logic [2:0]             nbytes;
  logic                   accept;
  logic                   in_font;
  logic                   reduce_go;
  logic                   col_done;
  logic                   row_done;
  logic [COL_W-1:0]       col_mod;
  logic [ROW_W-1:0]       row_mod;
  logic [7:0]             byte_data;
  logic [6:0]             glyph;
  ltw_pkg::load_t         ld;
  ltw_pkg::shift_status_t sh_status;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign in_font   = request.value inside {[ltw_pkg::FIRST_CODE:ltw_pkg::LAST_CODE]};
  assign reduce_go = accept && (request.command == ltw_pkg::CMD_SET_POS);
  assign glyph     = 7'(value - ltw_pkg::FIRST_CODE);

  // Column and row are reduced in parallel, one bit per cycle.
  ltw_mod_reduce #(.DIVISOR(TEXT_COLUMNS)) u_col_reduce (
    .clk       (clk),
    .rst       (rst),
    .go        (reduce_go),
    .dividend  (request.column),
    .done      (col_done),
    .remainder (col_mod)
  );

  ltw_mod_reduce #(.DIVISOR(TEXT_ROWS)) u_row_reduce (
    .clk       (clk),
    .rst       (rst),
    .go        (reduce_go),
    .dividend  (request.row),
    .done      (row_done),
    .remainder (row_mod)
  );

  // Pick the byte for the current position in the run.
  always_comb begin
    case (cmd)
      ltw_pkg::CMD_SET_POS: begin
        if (byte_idx == 3'd0) begin
          byte_data = ltw_pkg::ROW_BASE + 8'(row_mod);
        end else begin
          byte_data = ltw_pkg::COL_BASE + 8'(16'(col_mod) * 16'(CELL_PIXELS));
        end
      end
      ltw_pkg::CMD_CHAR: begin
        if (byte_idx == 3'd0) begin
          byte_data = 8'h00;
        end else begin
          byte_data = ltw_pkg::font_column(glyph, 3'(byte_idx - 3'd1));
        end
      end
      default: byte_data = value;
    endcase
  end

  // Load the next byte as the shifter sends the last bit of the previous one.
  always_comb begin
    ld.load      = (state == ST_SEND) && (byte_idx != nbytes) &&
                   (!sh_status.active || sh_status.ending);
    ld.data      = byte_data;
    ld.dc        = (cmd == ltw_pkg::CMD_CHAR) || (cmd == ltw_pkg::CMD_RAW_DATA);
    ld.last_byte = (3'(byte_idx + 3'd1) == nbytes);
  end

  ltw_shifter u_shifter (
    .clk    (clk),
    .rst    (rst),
    .ld     (ld),
    .status (sh_status),
    .strobe (strobe),
    .result (result)
  );

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      byte_idx <= '0;
      nbytes   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd      <= request.command;
            value    <= request.value;
            byte_idx <= '0;
            case (request.command)
              ltw_pkg::CMD_SET_POS: begin
                nbytes <= 3'd2;
                state  <= ST_REDUCE;
              end
              ltw_pkg::CMD_CHAR: begin
                nbytes <= 3'(ltw_pkg::CHAR_BYTES);
                if (in_font) begin
                  state <= ST_SEND;
                end
              end
              default: begin
                nbytes <= 3'd1;
                state  <= ST_SEND;
              end
            endcase
          end
        end
        ST_REDUCE: begin
          if (col_done && row_done) begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (ld.load) begin
            byte_idx <= byte_idx + 3'd1;
          end
          if ((byte_idx == nbytes) && sh_status.ending) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/ltw_checker.sv @@
// Port-level checks on the serial output framing.
module ltw_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input ltw_pkg::request_t request,
  input logic              strobe,
  input ltw_pkg::result_t  result
);

  // Serial bits only appear while a request is in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("serial bit shown while idle");

  // No bit goes out in the cycle right after a request is taken.
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe)
    else $error("serial bit right after request");

  // The final bit of a run always closes a byte.
  a_last_byte_end: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> result.byte_end)
    else $error("run ended inside a byte");

  // The block is free again once the run is over.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !busy)
    else $error("still busy after final bit");

  // Bits of one byte leave on consecutive cycles.
  a_byte_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.byte_end) |=> strobe)
    else $error("gap inside a byte");

endmodule

bind lcd_text_serial_writer ltw_checker u_checker (.*);
